>>> sv/r2c_pkg.sv
// ----------------------------------------------------------------------------
// r2c_pkg
// Shared constants and stage type for the RGB to CMYK converter.
// ----------------------------------------------------------------------------
package r2c_pkg;

  // channel width and full-scale code (all ones stands for 1.0)
  localparam int unsigned CHANNEL_BITS = 8;
  localparam logic [CHANNEL_BITS-1:0] FULL_SCALE = '1;

  // three ink lanes share the divider chain
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned LANE_CYAN = 0;
  localparam int unsigned LANE_MAGENTA = 1;
  localparam int unsigned LANE_YELLOW = 2;

  // state handed from cell to cell along the divider chain
  typedef struct packed {
    logic [CHANNEL_BITS-1:0]                black;
    logic [CHANNEL_BITS-1:0]                span;
    logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] rem;
    logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] low;
    logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] quo;
  } r2c_stage_t;

endpackage

>>> sv/rgb_to_cmyk_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_cmyk_convert
// RGB to CMYK pixel converter built on a chain of division cells.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock cycle while in_stall_o is low and returns one
// CMYK transaction per pixel in order. A pixel passes the front stage
// (inversion, black pick, dividend), which loads on the accepting edge, then
// one division cell per quotient bit, then the output register. The chain
// stalls only where it is full; empty stages fill while the output is
// stalled.
// A pure black pixel yields zero cyan, magenta and yellow with full black.
module rgb_to_cmyk_convert (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [r2c_pkg::CHANNEL_BITS-1:0] red_i,
  input  logic [r2c_pkg::CHANNEL_BITS-1:0] green_i,
  input  logic [r2c_pkg::CHANNEL_BITS-1:0] blue_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [r2c_pkg::CHANNEL_BITS-1:0] cyan_o,
  output logic [r2c_pkg::CHANNEL_BITS-1:0] magenta_o,
  output logic [r2c_pkg::CHANNEL_BITS-1:0] yellow_o,
  output logic [r2c_pkg::CHANNEL_BITS-1:0] black_o
);
  import r2c_pkg::*;

  logic       front_ready;
  logic       chain_valid [CHANNEL_BITS+1];
  logic       chain_ready [CHANNEL_BITS+1];
  r2c_stage_t chain_stage [CHANNEL_BITS+1];

  logic                    out_ready;
  logic                    out_valid_q;
  logic                    pure_black;
  logic [CHANNEL_BITS-1:0] cyan_q;
  logic [CHANNEL_BITS-1:0] magenta_q;
  logic [CHANNEL_BITS-1:0] yellow_q;
  logic [CHANNEL_BITS-1:0] black_q;

  // front stage
  r2c_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .stage_o (chain_stage[0])
  );

  assign in_stall_o = !front_ready;

  // division chain, one cell per quotient bit, MSB first
  for (genvar i = 0; i < CHANNEL_BITS; i++) begin : g_cell
    r2c_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .stage_i (chain_stage[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .stage_o (chain_stage[i+1])
    );
  end

  // output register
  assign out_ready                 = !out_valid_q || !out_stall_i;
  assign chain_ready[CHANNEL_BITS] = out_ready;
  assign pure_black = (chain_stage[CHANNEL_BITS].black == FULL_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= chain_valid[CHANNEL_BITS];
    end
  end

  // zero span means pure black: the quotient bits are meaningless there
  always_ff @(posedge clk_i) begin
    if (out_ready && chain_valid[CHANNEL_BITS]) begin
      cyan_q    <= pure_black ? '0 : chain_stage[CHANNEL_BITS].quo[LANE_CYAN];
      magenta_q <= pure_black ? '0 : chain_stage[CHANNEL_BITS].quo[LANE_MAGENTA];
      yellow_q  <= pure_black ? '0 : chain_stage[CHANNEL_BITS].quo[LANE_YELLOW];
      black_q   <= chain_stage[CHANNEL_BITS].black;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cyan_o      = cyan_q;
  assign magenta_o   = magenta_q;
  assign yellow_o    = yellow_q;
  assign black_o     = black_q;

endmodule

>>> sv/r2c_front.sv
// ----------------------------------------------------------------------------
// r2c_front
// Inverts the channels, picks black and forms the scaled dividends.
// ----------------------------------------------------------------------------
module r2c_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [r2c_pkg::CHANNEL_BITS-1:0]   red_i,
  input  logic [r2c_pkg::CHANNEL_BITS-1:0]   green_i,
  input  logic [r2c_pkg::CHANNEL_BITS-1:0]   blue_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output r2c_pkg::r2c_stage_t                stage_o
);
  import r2c_pkg::*;

  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] inv;
  logic [CHANNEL_BITS-1:0]                black;
  r2c_stage_t                             stage_d;
  r2c_stage_t                             stage_q;
  logic                                   valid_q;

  // inverses: FS - x is the bitwise complement
  assign inv[LANE_CYAN]    = FULL_SCALE - red_i;
  assign inv[LANE_MAGENTA] = FULL_SCALE - green_i;
  assign inv[LANE_YELLOW]  = FULL_SCALE - blue_i;

  // black is the least inverse
  always_comb begin
    black = inv[LANE_CYAN];
    if (inv[LANE_MAGENTA] < black) begin
      black = inv[LANE_MAGENTA];
    end
    if (inv[LANE_YELLOW] < black) begin
      black = inv[LANE_YELLOW];
    end
  end

  // dividend (x' - k) * FS as shift and subtract, split into high and low halves
  always_comb begin
    logic [CHANNEL_BITS-1:0]   diff;
    logic [2*CHANNEL_BITS-1:0] num;
    stage_d       = '0;
    stage_d.black = black;
    stage_d.span  = FULL_SCALE - black;
    for (int l = 0; l < NUM_LANES; l++) begin
      diff = inv[l] - black;
      num  = {diff, {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, diff};
      stage_d.rem[l] = num[2*CHANNEL_BITS-1:CHANNEL_BITS];
      stage_d.low[l] = num[CHANNEL_BITS-1:0];
      stage_d.quo[l] = '0;
    end
  end

  // stage register moves on when empty or when downstream takes it
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

>>> sv/r2c_div_cell.sv
// ----------------------------------------------------------------------------
// r2c_div_cell
// One restoring-division step: settles one quotient bit for all three lanes.
// ----------------------------------------------------------------------------
module r2c_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  r2c_pkg::r2c_stage_t stage_i,
  output logic                valid_o,
  input  logic                ready_i,
  output r2c_pkg::r2c_stage_t stage_o
);
  import r2c_pkg::*;

  r2c_stage_t stage_d;
  r2c_stage_t stage_q;
  logic       valid_q;

  // shift in the next dividend bit, subtract the span if it fits
  always_comb begin
    logic [CHANNEL_BITS:0]   trial;
    logic [CHANNEL_BITS+1:0] diff;
    stage_d = stage_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      trial = {stage_i.rem[l], stage_i.low[l][CHANNEL_BITS-1]};
      diff  = {1'b0, trial} - {2'b00, stage_i.span};
      stage_d.low[l] = {stage_i.low[l][CHANNEL_BITS-2:0], 1'b0};
      if (!diff[CHANNEL_BITS+1]) begin
        stage_d.rem[l] = diff[CHANNEL_BITS-1:0];
        stage_d.quo[l] = {stage_i.quo[l][CHANNEL_BITS-2:0], 1'b1};
      end else begin
        stage_d.rem[l] = trial[CHANNEL_BITS-1:0];
        stage_d.quo[l] = {stage_i.quo[l][CHANNEL_BITS-2:0], 1'b0};
      end
    end
  end

  // cell register with bubble collapse
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

>>> dv/rgb_to_cmyk_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_cmyk_convert_tb
// Self-checking bench for the RGB to CMYK pixel converter.
// ----------------------------------------------------------------------------
// Pixels are driven through the valid/stall input channel. A scoreboard
// computes the expected inks for every accepted pixel and compares them, in
// order, with each output transaction. The run covers extreme and special
// pixels first, then random pixels under several idle and stall mixes. It
// also includes a long output hold-off that backs the chain up to its input.
module rgb_to_cmyk_convert_tb;

  import r2c_pkg::*;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t cyan;
    chan_t magenta;
    chan_t yellow;
    chan_t black;
  } inks_t;

  // ink predictor and in-order store of expected inks
  class cmyk_scoreboard;
    inks_t       expected_inks[$];
    int unsigned error_count;

    function new();
      error_count = 0;
    endfunction

    // one ink from its inverse, black and the span left above black
    function chan_t scale_ink(chan_t inv, chan_t blk);
      logic [2*CHANNEL_BITS-1:0] prod;
      chan_t                     span;
      span = FULL_SCALE - blk;
      prod = (inv - blk) * FULL_SCALE;
      return chan_t'(prod / span);
    endfunction

    function inks_t convert_pixel(chan_t r, chan_t g, chan_t b);
      inks_t res;
      chan_t c_inv;
      chan_t m_inv;
      chan_t y_inv;
      chan_t blk;
      c_inv = FULL_SCALE - r;
      m_inv = FULL_SCALE - g;
      y_inv = FULL_SCALE - b;
      blk = c_inv;
      if (m_inv < blk) blk = m_inv;
      if (y_inv < blk) blk = y_inv;
      res.black = blk;
      // pure black pixel carries no colored ink
      if (blk == FULL_SCALE) begin
        res.cyan = '0;
        res.magenta = '0;
        res.yellow = '0;
      end else begin
        res.cyan = scale_ink(c_inv, blk);
        res.magenta = scale_ink(m_inv, blk);
        res.yellow = scale_ink(y_inv, blk);
      end
      return res;
    endfunction

    function void note_pixel(chan_t r, chan_t g, chan_t b);
      expected_inks.push_back(convert_pixel(r, g, b));
    endfunction

    function void check_inks(chan_t c, chan_t m, chan_t y, chan_t k);
      inks_t exp_inks;
      if (expected_inks.size() == 0) begin
        $error("unexpected output transaction: cyan %0d magenta %0d yellow %0d black %0d",
               c, m, y, k);
        error_count++;
        return;
      end
      exp_inks = expected_inks.pop_front();
      if (c !== exp_inks.cyan) begin
        $error("cyan mismatch: expected %0d, actual %0d", exp_inks.cyan, c);
        error_count++;
      end
      if (m !== exp_inks.magenta) begin
        $error("magenta mismatch: expected %0d, actual %0d", exp_inks.magenta, m);
        error_count++;
      end
      if (y !== exp_inks.yellow) begin
        $error("yellow mismatch: expected %0d, actual %0d", exp_inks.yellow, y);
        error_count++;
      end
      if (k !== exp_inks.black) begin
        $error("black mismatch: expected %0d, actual %0d", exp_inks.black, k);
        error_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_inks.size();
    endfunction
  endclass

  localparam int unsigned PIXELS_PER_PHASE = 340;
  localparam int unsigned NUM_PHASES = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned BURST_PIXELS = 60;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  chan_t red_i = '0;
  chan_t green_i = '0;
  chan_t blue_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  chan_t cyan_o;
  chan_t magenta_o;
  chan_t yellow_o;
  chan_t black_o;

  cmyk_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;

  rgb_to_cmyk_convert dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cyan_o      (cyan_o),
    .magenta_o   (magenta_o),
    .yellow_o    (yellow_o),
    .black_o     (black_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output stall: long hold-off when requested, random otherwise
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // check every output transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_inks(cyan_o, magenta_o, yellow_o, black_o);
    end
  end

  // one input transaction with random idle cycles ahead of it
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      red_i <= chan_t'($urandom);
      green_i <= chan_t'($urandom);
      blue_i <= chan_t'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(r, g, b);
  endtask

  // sender stays quiet until every expected transaction has come out
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
  endtask

  // pixel mix: uniform, gray, partly gray, near black, near white and full-on or off channels
  function automatic chan_t pick_channel(int unsigned mode, chan_t base);
    case (mode)
      5:       return base;
      6:       return chan_t'($urandom_range(3));
      7:       return $urandom_range(1) ? FULL_SCALE : chan_t'(0);
      8:       return FULL_SCALE - chan_t'($urandom_range(3));
      9:       return $urandom_range(2) == 0 ? chan_t'($urandom) : base;
      default: return chan_t'($urandom);
    endcase
  endfunction

  // run limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned mode;
    chan_t       base;
    chan_t       r;
    chan_t       g;
    chan_t       b;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed pixels: black, white, primaries, tiny spans, bit patterns
    send_pixel('0, '0, '0);
    send_pixel(FULL_SCALE, FULL_SCALE, FULL_SCALE);
    send_pixel(FULL_SCALE, '0, '0);
    send_pixel('0, FULL_SCALE, '0);
    send_pixel('0, '0, FULL_SCALE);
    send_pixel(FULL_SCALE, FULL_SCALE, '0);
    send_pixel('0, FULL_SCALE, FULL_SCALE);
    send_pixel(FULL_SCALE, '0, FULL_SCALE);
    send_pixel(chan_t'(1), chan_t'(1), chan_t'(1));
    send_pixel(chan_t'(1), '0, '0);
    send_pixel('0, '0, chan_t'(1));
    send_pixel(chan_t'(1), chan_t'(2), chan_t'(3));
    send_pixel(chan_t'(FULL_SCALE - 1), chan_t'(FULL_SCALE - 1), chan_t'(FULL_SCALE - 1));
    send_pixel(chan_t'(FULL_SCALE - 1), FULL_SCALE, FULL_SCALE);
    send_pixel(chan_t'(8'hAA), chan_t'(8'h55), '0);
    send_pixel(chan_t'(8'h55), chan_t'(8'hAA), FULL_SCALE);
    send_pixel(chan_t'(128), chan_t'(64), chan_t'(32));
    send_pixel(chan_t'(200), chan_t'(17), chan_t'(99));
    wait_drain();

    // random phases: none, sender idle, receiver stall, both
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      repeat (PIXELS_PER_PHASE) begin
        mode = $urandom_range(9);
        base = chan_t'($urandom);
        r = pick_channel(mode, base);
        g = pick_channel(mode, base);
        b = pick_channel(mode, base);
        send_pixel(r, g, b);
      end
      wait_drain();
    end

    // long output hold-off while pixels keep coming, filling the chain
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (BURST_PIXELS) begin
      send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
    end
    wait_drain();

    // let any stray transaction show up
    repeat (CHANNEL_BITS + 8) @(negedge clk_i);
    if (sb.error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
